>>> design/ntpd_pkg.sv
package ntpd_pkg;

  localparam int PwmLevelsDef = 64;
  localparam int NumTubes     = 4;
  localparam int NumSlots     = 11;   // slot 0 is the dot, slots 1..10 digits 0..9
  localparam int PatWidth     = 64;

  // input word
  typedef struct packed {
    logic       action;
    logic [3:0] digit0;
    logic [3:0] digit1;
    logic [3:0] digit2;
    logic [3:0] digit3;
    logic [3:0] dots;
  } in_t;

  // result word
  typedef struct packed {
    logic                send_valid;
    logic [PatWidth-1:0] pattern;
    logic                drive_update;
    logic [15:0]         drive_value;
  } out_t;

  // accepted-word events, top -> control
  typedef struct packed {
    logic tick;
    logic frame;
  } evt_t;

  typedef enum logic [1:0] {
    RegBrightness   = 2'd0,
    RegAnodeCompare = 2'd1,
    RegTubeEnable   = 2'd2
  } reg_idx_e;

  localparam logic [15:0] BrightnessRst   = 16'd15;
  localparam logic [15:0] AnodeCompareRst = 16'd0;
  localparam logic [3:0]  TubeEnableRst   = 4'hF;

  // driver bit position per tube and slot
  localparam logic [5:0] BitMap [NumTubes][NumSlots] = '{
    '{6'd43, 6'd37, 6'd32, 6'd47, 6'd46, 6'd45, 6'd33, 6'd34, 6'd35, 6'd44, 6'd36},
    '{6'd52, 6'd50, 6'd39, 6'd38, 6'd42, 6'd41, 6'd40, 6'd55, 6'd54, 6'd53, 6'd51},
    '{6'd12, 6'd26, 6'd25, 6'd14, 6'd13, 6'd11, 6'd10, 6'd9,  6'd8,  6'd23, 6'd22},
    '{6'd21, 6'd17, 6'd27, 6'd28, 6'd29, 6'd20, 6'd30, 6'd31, 6'd16, 6'd19, 6'd18}
  };

endpackage

>>> design/ntpd_lane.sv
// One tube: digit and dot to driver bits, at most one bit each.
module ntpd_lane (
  input  logic [1:0]                    tube_i,
  input  logic [3:0]                    digit_i,
  input  logic                          dot_i,
  input  logic                          en_i,
  output logic [ntpd_pkg::PatWidth-1:0] bits_o
);

  logic [3:0] slot;

  always_comb begin
    slot   = digit_i + 4'd1;
    bits_o = '0;
    if (en_i && (digit_i <= 4'd9)) begin
      bits_o[ntpd_pkg::BitMap[tube_i][slot]] = 1'b1;
    end
    if (dot_i) begin
      bits_o[ntpd_pkg::BitMap[tube_i][4'd0]] = 1'b1;
    end
  end

endmodule

>>> design/ntpd_ctrl.sv
// Pattern latch, PWM phase/level tracking and result register.
module ntpd_ctrl #(
  parameter int PWM_LEVELS = ntpd_pkg::PwmLevelsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ntpd_pkg::evt_t                ev_i,
  input  logic [ntpd_pkg::PatWidth-1:0] frame_pat_i,
  input  logic [15:0]                   brightness_i,
  input  logic [15:0]                   anode_compare_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output ntpd_pkg::out_t                out_data_o
);

  localparam int PhW = $clog2(PWM_LEVELS + 1);
  localparam logic [PhW-1:0] PhaseMax = PhW'(PWM_LEVELS);
  localparam logic [PhW-1:0] LevelMax = PhW'(PWM_LEVELS - 1);

  logic [ntpd_pkg::PatWidth-1:0] pat_q;
  logic                          pending_q;
  logic [PhW-1:0]                phase_q, phase_d;
  logic                          drive_on_q;
  logic                          out_valid_q;
  ntpd_pkg::out_t                out_q, out_d;

  logic [PhW-1:0] level;
  logic           on, send, upd;

  always_comb begin
    priority if (brightness_i >= 16'(PWM_LEVELS - 1)) begin
      level = LevelMax;
    end else if (brightness_i == 16'd0) begin
      level = PhW'(1);
    end else begin
      level = brightness_i[PhW-1:0];
    end
    on      = (phase_q <= level);
    send    = ev_i.tick && !drive_on_q && pending_q;
    upd     = ev_i.tick && (on != drive_on_q);
    phase_d = (phase_q == PhaseMax) ? '0 : phase_q + PhW'(1);

    out_d.send_valid   = send;
    out_d.pattern      = send ? pat_q : '0;
    out_d.drive_update = upd;
    out_d.drive_value  = (upd && on) ? anode_compare_i : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q       <= '0;
      pending_q   <= 1'b1;
      phase_q     <= '0;
      drive_on_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ev_i.frame) begin
        pat_q     <= frame_pat_i;
        pending_q <= 1'b1;
      end else if (send) begin
        pending_q <= 1'b0;
      end
      if (ev_i.tick) begin
        phase_q    <= phase_d;
        drive_on_q <= on;
      end
      if (send || upd) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (send || upd) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/nixie_tube_pwm_display_top.sv
// A tick word that yields a result shows it in the cycle after acceptance.
// Frame words yield no result; their pattern is latched on the accepting edge.
// Throughput: one word per cycle; the single result register stalls every word,
// frames included, while an unaccepted result is held and out_ready_i is low.
// Reset (rst_ni low, async): config regs to defaults, pattern cleared, send
// pending set, PWM phase zero, drive off, no result held.
module nixie_tube_pwm_display_top #(
  parameter int PWM_LEVELS = ntpd_pkg::PwmLevelsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // input words
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ntpd_pkg::in_t  in_data_i,
  // result words
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ntpd_pkg::out_t out_data_o,
  // APB config port
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  // ---------------------------------------------------------------------------
  // Config registers: brightness @0x0, anode_compare @0x4, tube_enable @0x8
  // ---------------------------------------------------------------------------
  logic [15:0]        brightness_q;
  logic [15:0]        anode_compare_q;
  logic [3:0]         tube_enable_q;
  ntpd_pkg::reg_idx_e reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = ntpd_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q    <= ntpd_pkg::BrightnessRst;
      anode_compare_q <= ntpd_pkg::AnodeCompareRst;
      tube_enable_q   <= ntpd_pkg::TubeEnableRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ntpd_pkg::RegBrightness:   brightness_q    <= pwdata[15:0];
        ntpd_pkg::RegAnodeCompare: anode_compare_q <= pwdata[15:0];
        ntpd_pkg::RegTubeEnable:   tube_enable_q   <= pwdata[3:0];
        default: ;  // unmapped slot, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ntpd_pkg::RegBrightness:   prdata = {16'd0, brightness_q};
      ntpd_pkg::RegAnodeCompare: prdata = {16'd0, anode_compare_q};
      ntpd_pkg::RegTubeEnable:   prdata = {28'd0, tube_enable_q};
      default:                   prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: a tick may need the result register, so it waits while a held
  // result is stalled. Holding ready off for frames too keeps the rule simple.
  // ---------------------------------------------------------------------------
  logic           in_fire;
  ntpd_pkg::evt_t ev;

  assign in_ready_o = !out_valid_o || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign ev.tick    = in_fire && !in_data_i.action;
  assign ev.frame   = in_fire &&  in_data_i.action;

  // ---------------------------------------------------------------------------
  // Four decode lanes, one per tube, then an OR merge into one pattern
  // ---------------------------------------------------------------------------
  logic [ntpd_pkg::NumTubes-1:0][3:0]                    lane_digit;
  logic [ntpd_pkg::NumTubes-1:0][ntpd_pkg::PatWidth-1:0] lane_bits;
  logic [ntpd_pkg::PatWidth-1:0]                         frame_pat;

  assign lane_digit[0] = in_data_i.digit0;
  assign lane_digit[1] = in_data_i.digit1;
  assign lane_digit[2] = in_data_i.digit2;
  assign lane_digit[3] = in_data_i.digit3;

  for (genvar t = 0; t < ntpd_pkg::NumTubes; t++) begin : g_lane
    ntpd_lane u_lane (
      .tube_i  (2'(t)),
      .digit_i (lane_digit[t]),
      .dot_i   (in_data_i.dots[t]),
      .en_i    (tube_enable_q[t]),
      .bits_o  (lane_bits[t])
    );
  end

  always_comb begin
    frame_pat = '0;
    for (int t = 0; t < ntpd_pkg::NumTubes; t++) begin
      frame_pat = frame_pat | lane_bits[t];
    end
  end

  // ---------------------------------------------------------------------------
  // PWM control and result register
  // ---------------------------------------------------------------------------
  ntpd_ctrl #(
    .PWM_LEVELS (PWM_LEVELS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ev_i            (ev),
    .frame_pat_i     (frame_pat),
    .brightness_i    (brightness_q),
    .anode_compare_i (anode_compare_q),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .out_data_o      (out_data_o)
  );

endmodule

>>> design/ntpd_checker.sv
module ntpd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input ntpd_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input ntpd_pkg::out_t out_data_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // a result always carries at least one event
  a_out_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.send_valid || out_data_o.drive_update)
    else $error("empty result word");

  // fields of an absent event are zero
  a_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.send_valid || out_data_o.pattern == '0) &&
                    (out_data_o.drive_update || out_data_o.drive_value == 16'd0))
    else $error("unused result field not zero");

  // a frame word never produces a result
  a_frame_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.action && !out_valid_o |=> !out_valid_o)
    else $error("frame word produced a result");

endmodule

bind nixie_tube_pwm_display_top ntpd_checker u_ntpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int PwmLevels  = ntpd_pkg::PwmLevelsDef;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;   // long receiver hold-off, in cycles
  localparam int HoldAfter  = 150;   // words accepted before the hold-off starts

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  ntpd_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  ntpd_pkg::out_t out_data_o;
  logic           psel        = 1'b0;
  logic           penable     = 1'b0;
  logic           pwrite      = 1'b0;
  logic [3:0]     paddr       = '0;
  logic [31:0]    pwdata      = '0;
  logic [31:0]    prdata;
  logic           pready;

  nixie_tube_pwm_display_top #(
    .PWM_LEVELS(PwmLevels)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  ntpd_pkg::in_t  word_q[$];        // words waiting to be offered
  ntpd_pkg::out_t nixie_out_q[$];   // predicted drive/send words, oldest first
  int             err_cnt        = 0;
  int             words_queued   = 0;
  int             words_accepted = 0;
  int             send_idle_pct  = 30;
  int             recv_idle_pct  = 65;
  int unsigned    cycle_cnt      = 0;
  int             hold_left      = 0;
  bit             hold_done      = 1'b0;

  // Shadow copy of the display: registers and state
  logic [15:0] cfg_bright  = ntpd_pkg::BrightnessRst;
  logic [15:0] cfg_compare = ntpd_pkg::AnodeCompareRst;
  logic [3:0]  cfg_enable  = ntpd_pkg::TubeEnableRst;
  logic [63:0] shadow_pat     = '0;
  logic        shadow_pending = 1'b1;
  int          shadow_phase   = 0;
  logic        shadow_on      = 1'b0;

  initial forever #4 clk_i = ~clk_i;

  // Run limit: a hung handshake ends here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL nixie_tube_pwm_display_top");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_cnt++;
    $display("%0t mismatch, %s: got %h want %h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Display step: applies one accepted word to the shadow state and queues
  // the drive/send word it causes, if any.
  // ---------------------------------------------------------------------------
  task automatic nixie_step(input ntpd_pkg::in_t w);
    logic [3:0]     digs [4];
    logic [63:0]    pat;
    int             lvl;
    int             phase;
    logic           on;
    logic           send;
    logic           update;
    ntpd_pkg::out_t r;
    if (w.action) begin
      // frame: map digits and dots to driver bits, mark pending
      digs = '{w.digit0, w.digit1, w.digit2, w.digit3};
      pat  = '0;
      for (int t = 0; t < ntpd_pkg::NumTubes; t++) begin
        // slot 0 is the dot, slot d+1 is digit d; dots ignore tube enable
        if (cfg_enable[t] && digs[t] <= 4'd9) pat[ntpd_pkg::BitMap[t][digs[t] + 1]] = 1'b1;
        if (w.dots[t]) pat[ntpd_pkg::BitMap[t][0]] = 1'b1;
      end
      shadow_pat     = pat;
      shadow_pending = 1'b1;
    end else begin
      // tick: a pending pattern only goes out while the tubes are dark
      send = !shadow_on && shadow_pending;
      if (send) shadow_pending = 1'b0;
      phase        = shadow_phase;
      shadow_phase = (phase + 1 >= PwmLevels + 1) ? 0 : phase + 1;
      lvl = (cfg_bright >= PwmLevels - 1) ? PwmLevels - 1 : int'(cfg_bright);
      if (lvl == 0) lvl = 1;
      on     = (phase <= lvl);
      update = (on != shadow_on);
      r = '0;
      r.send_valid = send;
      if (send) r.pattern = shadow_pat;
      if (update) begin
        shadow_on      = on;
        r.drive_update = 1'b1;
        r.drive_value  = on ? cfg_compare : 16'd0;
      end
      if (send || update) begin
        nixie_out_q.push_back(r);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: offers queued words, predicts on each acceptance.
  // Valid only drops once its word is taken; one NBA per signal per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : tx_drv
    logic busy;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        nixie_step(in_data_i);
        words_accepted++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= word_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-off, counted here; the monitor keeps ready low while
  // it runs and the sender keeps offering, so the block backs up.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : hold_ctl
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_accepted >= HoldAfter) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each accepted result word field by field and
  // drives out_ready_i.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : rx_mon
    ntpd_pkg::out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (nixie_out_q.size() == 0) begin
          report_mismatch("result word with none pending", out_data_o.pattern, '0);
        end else begin
          want = nixie_out_q.pop_front();
          if (out_data_o.send_valid !== want.send_valid)
            report_mismatch("send_valid", 64'(out_data_o.send_valid),
                            64'(want.send_valid));
          if (out_data_o.pattern !== want.pattern)
            report_mismatch("pattern", out_data_o.pattern, want.pattern);
          if (out_data_o.drive_update !== want.drive_update)
            report_mismatch("drive_update", 64'(out_data_o.drive_update),
                            64'(want.drive_update));
          if (out_data_o.drive_value !== want.drive_value)
            report_mismatch("drive_value", 64'(out_data_o.drive_value),
                            64'(want.drive_value));
        end
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Config port: setup then access phase; write lands with penable and pready
  // ---------------------------------------------------------------------------
  task automatic apb_xfer(input logic wr, input ntpd_pkg::reg_idx_e idx,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write, update the shadow, read back
  task automatic set_reg(input ntpd_pkg::reg_idx_e idx, input logic [15:0] value);
    logic [31:0] rd;
    logic [31:0] mask;
    apb_xfer(1'b1, idx, {16'd0, value}, rd);
    case (idx)
      ntpd_pkg::RegBrightness:   cfg_bright  = value;
      ntpd_pkg::RegAnodeCompare: cfg_compare = value;
      default:                   cfg_enable  = value[3:0];
    endcase
    mask = (idx == ntpd_pkg::RegTubeEnable) ? 32'h0000_000F : 32'h0000_FFFF;
    apb_xfer(1'b0, idx, '0, rd);
    if ((rd & mask) !== ({16'd0, value} & mask))
      report_mismatch("register readback", 64'(rd), 64'({16'd0, value} & mask));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_frame(input logic [3:0] d0, input logic [3:0] d1,
                                      input logic [3:0] d2, input logic [3:0] d3,
                                      input logic [3:0] dots);
    ntpd_pkg::in_t w;
    w.action = 1'b1;
    w.digit0 = d0;
    w.digit1 = d1;
    w.digit2 = d2;
    w.digit3 = d3;
    w.dots   = dots;
    word_q.push_back(w);
    words_queued++;
  endfunction

  function automatic void queue_tick();
    ntpd_pkg::in_t w = ntpd_pkg::in_t'($urandom);   // digit/dot fields are don't-care
    w.action = 1'b0;
    word_q.push_back(w);
    words_queued++;
  endfunction

  function automatic void queue_random_word();
    ntpd_pkg::in_t w = ntpd_pkg::in_t'($urandom);
    if ($urandom_range(99) < 25) begin
      w.action = 1'b1;
      // mostly showable digits, the rest keep the raw 0..15 spread
      if ($urandom_range(3) != 0) begin
        w.digit0 = 4'($urandom_range(9));
        w.digit1 = 4'($urandom_range(9));
        w.digit2 = 4'($urandom_range(9));
        w.digit3 = 4'($urandom_range(9));
      end
    end else begin
      w.action = 1'b0;
    end
    word_q.push_back(w);
    words_queued++;
  endfunction

  // drain: every queued word taken and every predicted result seen
  task automatic wait_idle();
    while (words_accepted != words_queued || nixie_out_q.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: tube 2 disabled to check blanking by enable
    set_reg(ntpd_pkg::RegBrightness, 16'd15);
    set_reg(ntpd_pkg::RegAnodeCompare, 16'h1234);
    set_reg(ntpd_pkg::RegTubeEnable, 16'h000B);

    queue_tick();                                  // first tick: send and turn-on together
    queue_frame(4'd0, 4'd1, 4'd2, 4'd3, 4'h0);
    queue_frame(4'd4, 4'd5, 4'd6, 4'd7, 4'hF);
    queue_frame(4'd8, 4'd9, 4'd10, 4'd15, 4'h5);   // out-of-range digits blank
    queue_frame(4'd9, 4'd0, 4'd12, 4'd11, 4'hA);
    queue_frame(4'd15, 4'd15, 4'd15, 4'd15, 4'h0); // all blank
    // walk past the on-window end: turn-off, then the pending frame goes out
    repeat (17) queue_tick();
    wait_idle();

    // random phases: idle mix changes every two, config every phase
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 65 : 0;
      recv_idle_pct = (ph < 2) ? 65 : (ph < 4) ? 30 : 0;
      case (ph)
        0: begin
          set_reg(ntpd_pkg::RegBrightness, 16'd0);           // acts as 1
          set_reg(ntpd_pkg::RegAnodeCompare, 16'hFFFF);
          set_reg(ntpd_pkg::RegTubeEnable, 16'h000F);
        end
        1: begin
          set_reg(ntpd_pkg::RegBrightness, 16'hFFFF);        // clamps to top level
          set_reg(ntpd_pkg::RegAnodeCompare, 16'h0000);      // zero compare still on
          set_reg(ntpd_pkg::RegTubeEnable, 16'h0000);
        end
        2: begin
          set_reg(ntpd_pkg::RegBrightness, 16'(PwmLevels - 1));
          set_reg(ntpd_pkg::RegAnodeCompare, 16'($urandom));
          set_reg(ntpd_pkg::RegTubeEnable, 16'($urandom_range(15)));
        end
        3: begin
          set_reg(ntpd_pkg::RegBrightness, 16'(PwmLevels - 2));
          set_reg(ntpd_pkg::RegAnodeCompare, 16'($urandom));
          set_reg(ntpd_pkg::RegTubeEnable, 16'($urandom_range(15)));
        end
        4: begin
          set_reg(ntpd_pkg::RegBrightness, 16'd1);
          set_reg(ntpd_pkg::RegAnodeCompare, 16'h8001);
          set_reg(ntpd_pkg::RegTubeEnable, 16'h0005);
        end
        default: begin
          set_reg(ntpd_pkg::RegBrightness, 16'($urandom_range(PwmLevels + 16)));
          set_reg(ntpd_pkg::RegAnodeCompare, 16'($urandom));
          set_reg(ntpd_pkg::RegTubeEnable, 16'($urandom_range(15)));
        end
      endcase
      repeat (155) queue_random_word();
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS nixie_tube_pwm_display_top");
    end else begin
      $display("FAIL nixie_tube_pwm_display_top");
    end
    $finish;
  end

endmodule
